@@ rtl/drs_pkg.sv @@
package drs_pkg;

    localparam int DefSlots = 16;

    localparam logic [1:0] PolFcfs  = 2'd0;
    localparam logic [1:0] PolSstf  = 2'd1;
    localparam logic [1:0] PolLook  = 2'd2;
    localparam logic [1:0] PolClook = 2'd3;

    localparam logic [1:0] StAdded  = 2'd0;
    localparam logic [1:0] StFull   = 2'd1;
    localparam logic [1:0] StServed = 2'd2;
    localparam logic [1:0] StEmpty  = 2'd3;

    localparam logic OpAdd   = 1'b0;
    localparam logic OpServe = 1'b1;

    localparam logic [31:0] TotalMax = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [15:0] cyl;
        logic [15:0] tag;
    } t_entry;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

@@ rtl/drs_cell.sv @@
module drs_cell
    import drs_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_load_data,
    input  t_entry    i_next,
    output t_entry    o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_load_data;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

@@ rtl/disk_request_scheduler_core.sv @@
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_stall         i_operation, i_cylinder, i_request_tag
// result    out        o_valid / i_stall         o_status .. o_pending_after
// config    in         i_cfg_valid / o_cfg_ready i_cfg_policy_mode
//
// An add or an empty serve goes from idle straight to emit; a serve passes through
// scan and pick, the scan rotating the cell row past one shared comparator.
// One item is in work at a time; the next is taken once the sequencer is idle.
// Reset empties the table, parks the head at cylinder one and sweeps upward.
// A stalled result holds the sequencer in its emit step.
module disk_request_scheduler_core
    import drs_pkg::*;
#(
    parameter int SLOTS = DefSlots
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_operation,
    input  logic [15:0]                i_cylinder,
    input  logic [15:0]                i_request_tag,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_status,
    output logic [15:0]                o_served_cylinder,
    output logic [15:0]                o_served_tag,
    output logic [15:0]                o_seek_distance,
    output logic [31:0]                o_total_seek,
    output logic [$clog2(SLOTS+1)-1:0] o_pending_after,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_policy_mode
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = $clog2(SLOTS);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PICK, S_EMIT} t_state;

    t_state          r_state;
    logic [1:0]      r_mode;
    logic [CW-1:0]   r_count;
    logic [15:0]     r_head;
    logic            r_down;
    logic [31:0]     r_total;
    logic [IW-1:0]   r_scan;

    // Scan candidates: first, nearest any, nearest up, nearest down, lowest.
    t_entry          r_first, r_any, r_up, r_dn, r_low;
    logic [IW-1:0]   r_any_i, r_up_i, r_dn_i, r_low_i;
    logic [15:0]     r_any_d, r_up_d, r_dn_d;
    logic            r_has_up, r_has_dn;

    logic [1:0]      r_res_status;
    t_entry          r_res_entry;
    logic [15:0]     r_res_dist;

    logic            r_out_valid;
    logic [1:0]      r_out_status;
    t_entry          r_out_entry;
    logic [15:0]     r_out_dist;
    logic [31:0]     r_out_total;
    logic [CW-1:0]   r_out_count;

    t_entry          w_cell [SLOTS];
    t_entry          w_load;
    logic            w_accept;
    logic            w_compact;

    // Selection at the end of the scan.
    t_entry       w_sel;
    logic [IW-1:0] w_sel_i;
    logic         w_flip;
    logic [15:0]  w_sel_d;
    logic [32:0]  w_sum;

    assign w_accept  = i_valid && !o_stall;
    assign w_load.cyl = i_cylinder;
    assign w_load.tag = i_request_tag;
    assign o_stall   = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_compact = (r_state == S_PICK);

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            t_cell_ctl w_ctl;
            always_comb begin
                w_ctl.load  = w_accept && (i_operation == OpAdd)
                              && (r_count == CW'(gi));
                w_ctl.shift = (r_state == S_SCAN)
                              || (w_compact && (IW'(gi) >= w_sel_i));
            end
            drs_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_load_data (w_load),
                .i_next      (w_cell[(gi + 1) % SLOTS]),
                .o_entry     (w_cell[gi])
            );
        end
    endgenerate

    // Scan datapath on the entry at the front of the row.
    logic [15:0] w_c;
    logic [15:0] w_d;
    logic        w_live;
    assign w_c    = w_cell[0].cyl;
    assign w_d    = (w_c >= r_head) ? (w_c - r_head) : (r_head - w_c);
    assign w_live = ({1'b0, r_scan} < (IW + 1)'(r_count));

    always_comb begin
        w_sel   = r_first;
        w_sel_i = '0;
        w_flip  = 1'b0;
        unique case (r_mode)
            PolFcfs: begin
                w_sel   = r_first;
                w_sel_i = '0;
            end
            PolSstf: begin
                w_sel   = r_any;
                w_sel_i = r_any_i;
            end
            PolLook: begin
                if (r_down ? r_has_dn : r_has_up) begin
                    w_sel   = r_down ? r_dn : r_up;
                    w_sel_i = r_down ? r_dn_i : r_up_i;
                end else begin
                    w_flip  = 1'b1;
                    w_sel   = r_down ? r_up : r_dn;
                    w_sel_i = r_down ? r_up_i : r_dn_i;
                end
            end
            default: begin
                if (r_has_up) begin
                    w_sel   = r_up;
                    w_sel_i = r_up_i;
                end else begin
                    w_sel   = r_low;
                    w_sel_i = r_low_i;
                end
            end
        endcase
        w_sel_d = (w_sel.cyl >= r_head) ? (w_sel.cyl - r_head) : (r_head - w_sel.cyl);
        w_sum   = {1'b0, r_total} + {17'd0, w_sel_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= PolFcfs;
            r_count     <= '0;
            r_head      <= 16'd1;
            r_down      <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_scan      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_policy_mode;
            end
            if (r_state == S_EMIT && (!r_out_valid || !i_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_entry <= '0;
                        r_res_dist  <= '0;
                        r_scan      <= '0;
                        r_has_up    <= 1'b0;
                        r_has_dn    <= 1'b0;
                        if (i_operation == OpAdd) begin
                            if (r_count < CW'(SLOTS)) begin
                                r_count      <= r_count + CW'(1);
                                r_res_status <= StAdded;
                            end else begin
                                r_res_status <= StFull;
                            end
                            r_state <= S_EMIT;
                        end else if (r_count == '0) begin
                            r_res_status <= StEmpty;
                            r_state      <= S_EMIT;
                        end else begin
                            r_res_status <= StServed;
                            r_state      <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_live) begin
                        if (r_scan == '0) begin
                            r_first <= w_cell[0];
                            r_any   <= w_cell[0];
                            r_any_i <= r_scan;
                            r_any_d <= w_d;
                            r_low   <= w_cell[0];
                            r_low_i <= r_scan;
                        end else begin
                            if (w_d < r_any_d) begin
                                r_any   <= w_cell[0];
                                r_any_i <= r_scan;
                                r_any_d <= w_d;
                            end
                            if (w_c < r_low.cyl) begin
                                r_low   <= w_cell[0];
                                r_low_i <= r_scan;
                            end
                        end
                        if (w_c >= r_head && (!r_has_up || w_d < r_up_d)) begin
                            r_has_up <= 1'b1;
                            r_up     <= w_cell[0];
                            r_up_i   <= r_scan;
                            r_up_d   <= w_d;
                        end
                        if (w_c <= r_head && (!r_has_dn || w_d < r_dn_d)) begin
                            r_has_dn <= 1'b1;
                            r_dn     <= w_cell[0];
                            r_dn_i   <= r_scan;
                            r_dn_d   <= w_d;
                        end
                    end
                    // After a full rotation the row is back in arrival order.
                    if (r_scan == IW'(SLOTS - 1)) begin
                        r_state <= S_PICK;
                    end else begin
                        r_scan <= r_scan + IW'(1);
                    end
                end
                S_PICK: begin
                    // The row closes the gap at the picked entry on this edge.
                    r_state <= S_EMIT;
                end
                default: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_status <= r_res_status;
                        r_out_entry  <= r_res_entry;
                        r_out_dist   <= r_res_dist;
                        r_out_total  <= r_total;
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
            endcase
            if (r_state == S_PICK) begin
                r_res_entry <= w_sel;
                r_res_dist  <= w_sel_d;
                r_head      <= w_sel.cyl;
                r_total     <= w_sum[32] ? TotalMax : w_sum[31:0];
                r_count     <= r_count - CW'(1);
                if (r_mode == PolLook && w_flip) begin
                    r_down <= !r_down;
                end
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_served_cylinder = r_out_entry.cyl;
    assign o_served_tag      = r_out_entry.tag;
    assign o_seek_distance   = r_out_dist;
    assign o_total_seek      = r_out_total;
    assign o_pending_after   = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("pending count above table size");

    a_added_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == StAdded) |-> (r_out_count != '0))
        else $error("add reported with empty table");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == StEmpty || r_out_status == StFull))
        |-> (r_out_dist == '0))
        else $error("nonzero seek on a result without service");

    a_scan_to_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) |=> (r_state == S_EMIT))
        else $error("pick step not followed by emit");

endmodule
